// ===== rtl/srr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the selective repeat receiver.
// Used by srr_front, srr_back, the top level and the checker.
package srr_pkg;

  localparam int SEQ_SPACE    = 16;
  localparam int WINDOW_MAX   = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SEQ_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WIN_W  = 4;
  localparam int CMP_W  = (SEQ_W > WIN_W) ? SEQ_W : WIN_W;
  localparam int HALF_SPACE = (SEQ_SPACE / 2 < 1) ? 1 : SEQ_SPACE / 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] payload;
  } q_item_t;

  // Window register clamped to [1, min(WINDOW_MAX, SEQ_SPACE/2)]
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] raw);
    logic [WIN_W-1:0] w;
    w = raw;
    if (w == '0) w = WIN_W'(1);
    if (int'(w) > WINDOW_MAX) w = WIN_W'(WINDOW_MAX);
    if (int'(w) > HALF_SPACE) w = WIN_W'(HALF_SPACE);
    return w;
  endfunction

endpackage

// ===== rtl/srr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts packets, drops those with a bad checksum and queues
// the good ones for the back end. Depends on srr_pkg.
module srr_front
  import srr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SEQ_W-1:0]        in_seq_num,
  input  logic [PAYLOAD_BITS-1:0] in_payload_word,
  input  logic                    in_checksum_ok,
  output logic                    q_valid,
  output q_item_t                 q_item,
  input  logic                    q_pop
);

  q_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push;

  // Classify: only good packets go on to the back end
  assign in_ready = (int'(cnt_r) < QUEUE_DEPTH);
  assign push     = in_valid && in_ready && in_checksum_ok;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !q_pop) cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    else if (!push && q_pop) cnt_nxt = QCNT_W'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].seq     <= in_seq_num;
      mem_r[wr_ptr_r].payload <= in_payload_word;
    end
  end

endmodule

// ===== rtl/srr_back.sv =====
`timescale 1ns / 1ps
// Back end: acknowledges, buffers in-window packets in a slot ring and
// delivers the in-order run from the receive base. Depends on srr_pkg.
module srr_back
  import srr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  q_item_t                 q_item,
  output logic                    q_pop,
  input  logic                    cfg_valid,
  input  logic [WIN_W-1:0]        cfg_window_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic [SEQ_W-1:0]        out_ack_number,
  output logic [SEQ_W-1:0]        out_delivered_seq,
  output logic [PAYLOAD_BITS-1:0] out_delivered_payload,
  output logic                    out_last
);

  typedef enum logic {ST_ACK, ST_DLV} state_t;

  state_t                  state_r, state_nxt;
  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [WINDOW_MAX-1:0]   valid_r, valid_nxt;
  logic [WIN_W-1:0]        win_r, win_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r [WINDOW_MAX];

  logic                    out_valid_r, out_valid_nxt;
  logic                    kind_r, kind_nxt;
  logic [SEQ_W-1:0]        ack_r, ack_nxt;
  logic [SEQ_W-1:0]        dseq_r, dseq_nxt;
  logic [PAYLOAD_BITS-1:0] dpay_r, dpay_nxt;
  logic                    last_r, last_nxt;

  logic                    out_free;
  logic [SEQ_W:0]          diff;
  logic [SEQ_W-1:0]        offset;
  logic                    in_win;
  logic [SLOT_W:0]         idx_sum;
  logic [SLOT_W-1:0]       ins_idx;
  logic [SLOT_W-1:0]       head_p1;
  logic [SEQ_W-1:0]        base_p1;
  logic                    pay_we;
  logic                    run;
  logic                    more;

  assign out_free = !out_valid_r || out_ready;

  // Offset of the packet from the receive base, modulo the sequence space
  always_comb begin
    if (q_item.seq >= base_r) diff = {1'b0, q_item.seq} - {1'b0, base_r};
    else diff = {1'b0, q_item.seq} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, base_r};
    offset = diff[SEQ_W-1:0];
  end

  assign in_win = (CMP_W'(offset) < CMP_W'(eff_window(win_r)));

  // Slot ring index: head plus offset, wrapped once
  always_comb begin
    idx_sum = {1'b0, head_r} + (SLOT_W+1)'(offset);
    if (int'(idx_sum) >= WINDOW_MAX) idx_sum = idx_sum - (SLOT_W+1)'(WINDOW_MAX);
    ins_idx = idx_sum[SLOT_W-1:0];
  end

  assign head_p1 = (int'(head_r) == WINDOW_MAX - 1) ? '0 : SLOT_W'(head_r + 1'b1);
  assign base_p1 = (int'(base_r) == SEQ_SPACE - 1) ? '0 : SEQ_W'(base_r + 1'b1);

  // A run follows the ack if the base slot is (or becomes) filled
  assign run  = in_win && ((offset == '0) || valid_r[head_r]);
  assign more = valid_r[head_p1] && (head_p1 != head_r);

  assign pay_we = (state_r == ST_ACK) && q_valid && out_free && in_win && !valid_r[ins_idx];

  // Sequencer: one result per cycle when the output is free
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    head_nxt      = head_r;
    valid_nxt     = valid_r;
    win_nxt       = cfg_valid ? cfg_window_size : win_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    ack_nxt       = ack_r;
    dseq_nxt      = dseq_r;
    dpay_nxt      = dpay_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_ACK: begin
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          if (pay_we) valid_nxt[ins_idx] = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ACK;
          ack_nxt       = q_item.seq;
          dseq_nxt      = '0;
          dpay_nxt      = '0;
          last_nxt      = !run;
          state_nxt     = run ? ST_DLV : ST_ACK;
        end
      end
      ST_DLV: begin
        if (out_free) begin
          valid_nxt[head_r] = 1'b0;
          out_valid_nxt     = 1'b1;
          kind_nxt          = KIND_DLV;
          ack_nxt           = '0;
          dseq_nxt          = base_r;
          dpay_nxt          = pay_r[head_r];
          last_nxt          = !more;
          base_nxt          = base_p1;
          head_nxt          = head_p1;
          state_nxt         = more ? ST_DLV : ST_ACK;
        end
      end
      default: state_nxt = ST_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACK;
      base_r      <= '0;
      head_r      <= '0;
      valid_r     <= '0;
      win_r       <= WINDOW_RESET;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_ACK;
      ack_r       <= '0;
      dseq_r      <= '0;
      dpay_r      <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      ack_r       <= ack_nxt;
      dseq_r      <= dseq_nxt;
      dpay_r      <= dpay_nxt;
      last_r      <= last_nxt;
    end
  end

  // Payload slots, written once per fill
  always_ff @(posedge clk) begin
    if (pay_we) pay_r[ins_idx] <= q_item.payload;
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = kind_r;
  assign out_ack_number        = ack_r;
  assign out_delivered_seq     = dseq_r;
  assign out_delivered_payload = dpay_r;
  assign out_last              = last_r;

endmodule

// ===== rtl/selective_repeat_receiver_unit.sv =====
`timescale 1ns / 1ps
// Selective repeat ARQ receiver, top level.
// Channels: in_* carries packets (sequence number, payload word, checksum
// flag); out_* carries results, each an ack (kind 0) or an in-order
// delivery (kind 1), with out_last on the final result of each packet;
// cfg_* writes the receive window width and is always ready.
// Packets with a bad checksum are taken and dropped with no result.
// Each packet passes through the two-entry queue, then its ack is
// registered in the output register. The sequencer driving the single
// output register emits one result per cycle while the output is free,
// and a packet yields its ack plus up to eight in-order deliveries.
// Reset clears the receive base, the slot valid bits, the queue and the
// output register, and sets the window to 8.
// When the receiver holds out_ready low the output register keeps its
// result, the back end waits, the queue fills and in_ready drops.
// Depends on srr_pkg, srr_front and srr_back.
module selective_repeat_receiver_unit
  import srr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SEQ_W-1:0]        in_seq_num,
  input  logic [PAYLOAD_BITS-1:0] in_payload_word,
  input  logic                    in_checksum_ok,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [WIN_W-1:0]        cfg_window_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic [SEQ_W-1:0]        out_ack_number,
  output logic [SEQ_W-1:0]        out_delivered_seq,
  output logic [PAYLOAD_BITS-1:0] out_delivered_payload,
  output logic                    out_last
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  assign cfg_ready = 1'b1;

  // Front end with the packet queue
  srr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_seq_num      (in_seq_num),
    .in_payload_word (in_payload_word),
    .in_checksum_ok  (in_checksum_ok),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back end: window, slot ring and result sequencer
  srr_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .cfg_valid             (cfg_valid),
    .cfg_window_size       (cfg_window_size),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_ack_number        (out_ack_number),
    .out_delivered_seq     (out_delivered_seq),
    .out_delivered_payload (out_delivered_payload),
    .out_last              (out_last)
  );

endmodule

// ===== rtl/srr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the selective repeat receiver, bound to the top.
// Depends on srr_pkg.
module srr_checker
  import srr_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_kind,
  input logic [SEQ_W-1:0]        out_ack_number,
  input logic [SEQ_W-1:0]        out_delivered_seq,
  input logic [PAYLOAD_BITS-1:0] out_delivered_payload,
  input logic                    out_last
);

  // A stalled result stays valid and holds its kind, last flag and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_delivered_payload))
    else $error("stalled result changed");

  // Unused fields are zero
  a_ack_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACK) |-> (out_delivered_seq == '0)
      && (out_delivered_payload == '0))
    else $error("ack carries delivery fields");

  a_dlv_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DLV) |-> (out_ack_number == '0))
    else $error("delivery carries ack number");

  // A result that is not last is followed at once by a delivery
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && (out_kind == KIND_DLV))
    else $error("run broken after non-last result");

  // Deliveries in a run carry consecutive sequence numbers
  a_run_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last && (out_kind == KIND_DLV)
      |=> out_delivered_seq == ((int'($past(out_delivered_seq)) == SEQ_SPACE - 1)
        ? SEQ_W'(0) : SEQ_W'($past(out_delivered_seq) + 1'b1)))
    else $error("delivery out of order");

endmodule

bind selective_repeat_receiver_unit srr_checker u_srr_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for selective_repeat_receiver_unit: sends packets and
// window writes, predicts acks and in-order deliveries, and checks each result.
// Depends on srr_pkg and the receiver RTL.
module tb_top;
  import srr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 14;

  typedef struct packed {
    logic                    kind;
    logic [SEQ_W-1:0]        ack;
    logic [SEQ_W-1:0]        dseq;
    logic [PAYLOAD_BITS-1:0] dpay;
    logic                    last;
  } rx_result_t;

  // DUT inputs, all driven to known values from time zero
  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic [SEQ_W-1:0]        in_seq_num      = '0;
  logic [PAYLOAD_BITS-1:0] in_payload_word = '0;
  logic                    in_checksum_ok  = 1'b0;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [WIN_W-1:0]        cfg_window_size = '0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic                    out_kind;
  logic [SEQ_W-1:0]        out_ack_number;
  logic [SEQ_W-1:0]        out_delivered_seq;
  logic [PAYLOAD_BITS-1:0] out_delivered_payload;
  logic                    out_last;

  // Receiver state as predicted from accepted packets
  logic [SEQ_W-1:0]        rx_base = '0;
  logic                    slot_vld [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0] slot_pay [WINDOW_MAX];
  logic [WIN_W-1:0]        win_reg = WINDOW_RESET;
  rx_result_t              pending_results [$];

  int  err_count    = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  bit  src_idle_on  = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  hold_req     = 1'b0;

  selective_repeat_receiver_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_seq_num            (in_seq_num),
    .in_payload_word       (in_payload_word),
    .in_checksum_ok        (in_checksum_ok),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_window_size       (cfg_window_size),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_ack_number        (out_ack_number),
    .out_delivered_seq     (out_delivered_seq),
    .out_delivered_payload (out_delivered_payload),
    .out_last              (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      slot_vld[i] = 1'b0;
      slot_pay[i] = '0;
    end
  end

  // Window register clamped to 1 .. min(WINDOW_MAX, half the sequence space)
  function automatic int window_span(input logic [WIN_W-1:0] raw);
    int w;
    int half;
    w    = int'(raw);
    half = SEQ_SPACE / 2;
    if (half < 1) half = 1;
    if (w == 0) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (w > half) w = half;
    return w;
  endfunction

  // Ack, buffering and in-order release for one accepted packet
  task automatic compute_packet_results(input logic [SEQ_W-1:0] seq,
                                        input logic [PAYLOAD_BITS-1:0] pay,
                                        input logic ok);
    rx_result_t batch [$];
    rx_result_t r;
    int offset;
    int run;
    if (!ok) return;
    r      = '0;
    r.kind = KIND_ACK;
    r.ack  = seq;
    batch.insert(batch.size(), r);
    offset = (int'(seq) + SEQ_SPACE - int'(rx_base)) % SEQ_SPACE;
    if (offset < window_span(win_reg) && offset < WINDOW_MAX) begin
      // duplicates keep the first payload
      if (!slot_vld[offset]) begin
        slot_vld[offset] = 1'b1;
        slot_pay[offset] = pay;
      end
      run = 0;
      while (run < WINDOW_MAX && slot_vld[run]) begin
        r      = '0;
        r.kind = KIND_DLV;
        r.dseq = rx_base;
        r.dpay = slot_pay[run];
        batch.insert(batch.size(), r);
        rx_base = SEQ_W'((int'(rx_base) + 1) % SEQ_SPACE);
        run++;
      end
      if (run > 0) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
          if (i + run < WINDOW_MAX) begin
            slot_vld[i] = slot_vld[i + run];
            slot_pay[i] = slot_pay[i + run];
          end else begin
            slot_vld[i] = 1'b0;
            slot_pay[i] = '0;
          end
        end
      end
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_results.insert(pending_results.size(), batch[i]);
  endtask

  task automatic report_field(input string name, input logic [PAYLOAD_BITS-1:0] exp_v,
                              input logic [PAYLOAD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Predict on accepted packets and window writes, check accepted results
  always @(posedge clk) begin : monitor
    rx_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        compute_packet_results(in_seq_num, in_payload_word, in_checksum_ok);
      if (cfg_valid && cfg_ready)
        win_reg = cfg_window_size;
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: extra result, expected none, actual kind %0d ack %0d",
                   $time, out_kind, out_ack_number,
                   " seq %0d payload %h last %0d",
                   out_delivered_seq, out_delivered_payload, out_last);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          report_field("kind", PAYLOAD_BITS'(want.kind), PAYLOAD_BITS'(out_kind));
          report_field("ack_number", PAYLOAD_BITS'(want.ack),
                       PAYLOAD_BITS'(out_ack_number));
          report_field("delivered_seq", PAYLOAD_BITS'(want.dseq),
                       PAYLOAD_BITS'(out_delivered_seq));
          report_field("delivered_payload", want.dpay, out_delivered_payload);
          report_field("last", PAYLOAD_BITS'(want.last), PAYLOAD_BITS'(out_last));
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_cnt;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one packet, with an optional idle burst first; returns on acceptance
  task automatic send_packet(input logic [SEQ_W-1:0] seq,
                             input logic [PAYLOAD_BITS-1:0] pay, input logic ok);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_seq_num      <= seq;
    in_payload_word <= pay;
    in_checksum_ok  <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drain everything expected, then let the back end settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    wait_idle();
    cfg_valid       <= 1'b1;
    cfg_window_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-window packets, some just past the edge, some anywhere
  task automatic send_random_packet();
    int span;
    int pick;
    logic [SEQ_W-1:0] seq;
    span = window_span(win_reg);
    pick = $urandom_range(0, 9);
    if (pick < 7)
      seq = rx_base + SEQ_W'($urandom_range(0, span - 1));
    else if (pick < 8)
      seq = rx_base + SEQ_W'(span);
    else
      seq = SEQ_W'($urandom);
    send_packet(seq, $urandom, $urandom_range(0, 9) != 0);
  endtask

  // One whole window in shuffled order, with the odd corrupted copy
  task automatic send_window_shuffled();
    int order [WINDOW_MAX];
    int span;
    int j;
    int t;
    logic [SEQ_W-1:0] seq;
    span = window_span(win_reg);
    for (int i = 0; i < span; i++) order[i] = i;
    for (int i = span - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < span; i++) begin
      seq = rx_base + SEQ_W'(order[i]);
      if ($urandom_range(0, 7) == 0)
        send_packet(seq, $urandom, 1'b0);
      send_packet(seq, $urandom, 1'b1);
    end
  endtask

  task automatic send_mixed(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 2) == 0)
        send_window_shuffled();
      else
        send_random_packet();
    end
  endtask

  // Reset state, window 8: drops, duplicates, stale and out-of-window packets
  task automatic test_basic_cases();
    send_packet(4'd0, 32'h0000_0000, 1'b1);
    send_packet(4'd1, 32'hFFFF_FFFF, 1'b0);
    send_packet(4'd2, 32'hFFFF_FFFF, 1'b1);
    send_packet(4'd2, 32'h1234_5678, 1'b1);
    send_packet(4'd1, 32'hA5A5_A5A5, 1'b1);
    send_packet(4'd1, 32'h0F0F_0F0F, 1'b1);
    send_packet(4'd11, 32'hDEAD_BEEF, 1'b1);
    send_packet(4'd15, 32'h5A5A_5A5A, 1'b1);
    send_packet(4'd10, 32'h8000_0001, 1'b1);
    wait_idle();
  endtask

  // Fill the window from the top, then the base packet releases all of it
  task automatic test_full_release();
    logic [SEQ_W-1:0] base;
    base = rx_base;
    for (int k = WINDOW_MAX - 1; k >= 1; k--)
      send_packet(base + SEQ_W'(k), $urandom, 1'b1);
    send_packet(base, $urandom, 1'b1);
    wait_idle();
  endtask

  // Buffered packets survive a window shrink and are released later
  task automatic test_window_shrink();
    logic [SEQ_W-1:0] base;
    write_window(4'd8);
    base = rx_base;
    send_packet(base + 4'd3, $urandom, 1'b1);
    write_window(4'd1);
    send_packet(base + 4'd5, $urandom, 1'b1);
    send_packet(base, $urandom, 1'b1);
    send_packet(base + 4'd1, $urandom, 1'b1);
    send_packet(base + 4'd2, $urandom, 1'b1);
    wait_idle();
  endtask

  // Random traffic under each window setting, both sides idling
  task automatic test_window_settings();
    logic [WIN_W-1:0] settings [6];
    settings = '{4'd15, 4'd0, 4'd1, 4'd3, 4'd5, 4'd8};
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    foreach (settings[i]) begin
      write_window(settings[i]);
      send_mixed(PHASE_ITEMS);
    end
    wait_idle();
  endtask

  // Long result stall while packets keep coming: input must back up
  task automatic test_output_stall();
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    send_window_shuffled();
    send_window_shuffled();
    wait_idle();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_mixed(PHASE_ITEMS);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_cases();
    test_full_release();
    test_window_shrink();
    test_window_settings();
    test_output_stall();
    test_streaming();
    $display("Sent %0d packets and checked %0d results over window values 0, 1, 3, 5, 8, 15,",
             items_sent, results_seen);
    $display("with a full in-order release, a shrunk window and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
